// File: design/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg - CIGAR string parser definitions
// Operation codes, error codes, the byte-to-operation lookup and the reference/query use of each operation.
// ----------------------------------------------------------------------------
package csp_pkg;

    typedef logic [3:0] op_code_t;
    typedef logic [1:0] err_code_t;

    localparam op_code_t OP_M     = 4'd0;
    localparam op_code_t OP_I     = 4'd1;
    localparam op_code_t OP_D     = 4'd2;
    localparam op_code_t OP_N     = 4'd3;
    localparam op_code_t OP_S     = 4'd4;
    localparam op_code_t OP_H     = 4'd5;
    localparam op_code_t OP_P     = 4'd6;
    localparam op_code_t OP_EQ    = 4'd7;
    localparam op_code_t OP_X     = 4'd8;
    localparam op_code_t OP_NONE  = 4'd15;

    localparam err_code_t ERR_OK       = 2'd0;
    localparam err_code_t ERR_UNKNOWN  = 2'd1;
    localparam err_code_t ERR_MISSING  = 2'd2;
    localparam err_code_t ERR_OVERFLOW = 2'd3;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    function automatic op_code_t letter_code(input logic [7:0] c);
        op_code_t code;
        case (c)
            8'h4D:   code = OP_M;   // 'M'
            8'h49:   code = OP_I;   // 'I'
            8'h44:   code = OP_D;   // 'D'
            8'h4E:   code = OP_N;   // 'N'
            8'h53:   code = OP_S;   // 'S'
            8'h48:   code = OP_H;   // 'H'
            8'h50:   code = OP_P;   // 'P'
            8'h3D:   code = OP_EQ;  // '='
            8'h58:   code = OP_X;   // 'X'
            default: code = OP_NONE;
        endcase
        return code;
    endfunction

    function automatic logic consumes_ref(input op_code_t code);
        return (code == OP_M) || (code == OP_D) || (code == OP_N) ||
               (code == OP_EQ) || (code == OP_X);
    endfunction

    function automatic logic consumes_query(input op_code_t code);
        return (code == OP_M) || (code == OP_I) || (code == OP_S) ||
               (code == OP_EQ) || (code == OP_X);
    endfunction

endpackage

// File: design/cigar_string_parser.sv
// ----------------------------------------------------------------------------
// cigar_string_parser - CIGAR text parser
// Gathers decimal run lengths byte by byte and emits one operation per letter
// (an unknown non-digit byte emits an error item) with running reference, query and common totals.
// ----------------------------------------------------------------------------
// Path: input register, then result register. Throughput: one byte per cycle
// unless a non-digit byte waits on a full, unaccepted result; the digit
// multiply-add and the saturating total adds sit in one stage between the two
// registers. Reset (aresetn low, synchronous): both stages empty, pending length,
// flags and totals cleared. The end-of-text byte clears all but the stages after use.
// ----------------------------------------------------------------------------
module cigar_string_parser #(
    parameter int LENGTH_BITS = 32,
    parameter int TOTAL_BITS  = 48
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_in,
    input  logic        s_end_of_text,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_op_code,
    output logic [31:0] m_op_length,
    output logic [47:0] m_ref_total,
    output logic [47:0] m_query_total,
    output logic [47:0] m_common_total,
    output logic [1:0]  m_error_code,
    output logic        m_last_op
);

    localparam int LB = LENGTH_BITS;
    localparam int TB = TOTAL_BITS;
    localparam int LW = LB + 4;
    localparam int SW = ((LB > TB) ? LB : TB) + 1;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // parser state
    logic [LB-1:0] pending_reg, pending_next;
    logic          have_digits_reg, have_digits_next;
    logic          overflow_reg, overflow_next;
    logic [TB-1:0] ref_sum_reg, ref_sum_next;
    logic [TB-1:0] query_sum_reg, query_sum_next;
    logic [TB-1:0] both_sum_reg, both_sum_next;

    // result stage
    logic               out_valid_reg;
    csp_pkg::op_code_t  op_code_reg, op_code_next;
    logic [31:0]        op_length_reg, op_length_next;
    logic [47:0]        ref_total_reg, ref_total_next;
    logic [47:0]        query_total_reg, query_total_next;
    logic [47:0]        common_total_reg, common_total_next;
    csp_pkg::err_code_t error_reg, error_next;
    logic               last_reg;

    logic              is_digit;
    logic              advance;
    logic              load_out;
    csp_pkg::op_code_t code;
    logic [LW-1:0]     prod;
    logic [LB-1:0]     len;
    logic [63:0]       len64;
    logic [63:0]       ref64, query64, both64;

    function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a,
                                              input logic [LB-1:0] b);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(b);
        if (s > SW'({TB{1'b1}}))
            return {TB{1'b1}};
        return s[TB-1:0];
    endfunction

    always_comb begin
        is_digit = in_char_reg inside {[csp_pkg::CHAR_ZERO:csp_pkg::CHAR_NINE]};
        code     = csp_pkg::letter_code(in_char_reg);
        advance  = in_valid_reg && (is_digit || !out_valid_reg || m_ready);
        load_out = advance && !is_digit;
        s_ready  = !in_valid_reg || advance;

        // pending * 10 + digit, wide enough to see overflow
        prod = (LW'(pending_reg) << 3) + (LW'(pending_reg) << 1)
             + LW'(in_char_reg - csp_pkg::CHAR_ZERO);

        pending_next     = pending_reg;
        have_digits_next = have_digits_reg;
        overflow_next    = overflow_reg;
        ref_sum_next     = ref_sum_reg;
        query_sum_next   = query_sum_reg;
        both_sum_next    = both_sum_reg;
        len              = '0;
        op_code_next     = code;
        error_next       = csp_pkg::ERR_OK;

        if (is_digit) begin
            if (prod[LW-1:LB] != '0) begin
                pending_next  = {LB{1'b1}};
                overflow_next = 1'b1;
            end else begin
                pending_next = prod[LB-1:0];
            end
            have_digits_next = 1'b1;
        end else begin
            if (code == csp_pkg::OP_NONE) begin
                op_code_next = csp_pkg::OP_M;
                error_next   = csp_pkg::ERR_UNKNOWN;
            end else if (!have_digits_reg) begin
                error_next = csp_pkg::ERR_MISSING;
            end else begin
                len        = pending_reg;
                error_next = overflow_reg ? csp_pkg::ERR_OVERFLOW : csp_pkg::ERR_OK;
                if (csp_pkg::consumes_ref(code))
                    ref_sum_next = sat_add(ref_sum_reg, pending_reg);
                if (csp_pkg::consumes_query(code))
                    query_sum_next = sat_add(query_sum_reg, pending_reg);
                if (csp_pkg::consumes_ref(code) && csp_pkg::consumes_query(code))
                    both_sum_next = sat_add(both_sum_reg, pending_reg);
            end
            pending_next     = '0;
            have_digits_next = 1'b0;
            overflow_next    = 1'b0;
        end

        len64             = 64'(len);
        ref64             = 64'(ref_sum_next);
        query64           = 64'(query_sum_next);
        both64            = 64'(both_sum_next);
        op_length_next    = len64[31:0];
        ref_total_next    = ref64[47:0];
        query_total_next  = query64[47:0];
        common_total_next = both64[47:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            pending_reg     <= '0;
            have_digits_reg <= 1'b0;
            overflow_reg    <= 1'b0;
            ref_sum_reg     <= '0;
            query_sum_reg   <= '0;
            both_sum_reg    <= '0;
        end else begin
            if (s_valid && s_ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;

            if (advance) begin
                if (in_last_reg) begin
                    pending_reg     <= '0;
                    have_digits_reg <= 1'b0;
                    overflow_reg    <= 1'b0;
                    ref_sum_reg     <= '0;
                    query_sum_reg   <= '0;
                    both_sum_reg    <= '0;
                end else begin
                    pending_reg     <= pending_next;
                    have_digits_reg <= have_digits_next;
                    overflow_reg    <= overflow_next;
                    ref_sum_reg     <= ref_sum_next;
                    query_sum_reg   <= query_sum_next;
                    both_sum_reg    <= both_sum_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_in;
            in_last_reg <= s_end_of_text;
        end
        if (load_out) begin
            op_code_reg      <= op_code_next;
            op_length_reg    <= op_length_next;
            ref_total_reg    <= ref_total_next;
            query_total_reg  <= query_total_next;
            common_total_reg <= common_total_next;
            error_reg        <= error_next;
            last_reg         <= in_last_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_op_code      = op_code_reg;
    assign m_op_length    = op_length_reg;
    assign m_ref_total    = ref_total_reg;
    assign m_query_total  = query_total_reg;
    assign m_common_total = common_total_reg;
    assign m_error_code   = error_reg;
    assign m_last_op      = last_reg;

    // an unknown byte always reports the M slot with no length
    a_unknown_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_code == csp_pkg::ERR_UNKNOWN) |->
            (m_op_code == csp_pkg::OP_M && m_op_length == 32'd0))
        else $error("unknown-character item carries op or length");

    // a pending result is never dropped while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_op_length) && $stable(m_ref_total)))
        else $error("stalled result lost or changed");

    // a non-digit byte leaves the input stage only if the result stage can take it
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && out_valid_reg) |-> m_ready)
        else $error("result register overwritten while full");

endmodule
